// ===== hdl/gdds_pkg.sv =====
`default_nettype none

package gdds_pkg;

   // Command codes carried in the request.
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_ADD  = 2'd1;
   localparam logic [1:0] CMD_SUB  = 2'd2;

   // Calendar limits.
   localparam logic [13:0] FIRST_YEAR = 14'd1900;
   localparam logic [13:0] LAST_YEAR  = 14'd9999;
   localparam logic [3:0]  JANUARY    = 4'd1;
   localparam logic [3:0]  FEBRUARY   = 4'd2;
   localparam logic [3:0]  APRIL      = 4'd4;
   localparam logic [3:0]  JUNE       = 4'd6;
   localparam logic [3:0]  SEPTEMBER  = 4'd9;
   localparam logic [3:0]  NOVEMBER   = 4'd11;
   localparam logic [3:0]  DECEMBER   = 4'd12;
   localparam logic [4:0]  FIRST_DAY  = 5'd1;
   localparam logic [4:0]  LAST_DAY_OF_DECEMBER = 5'd31;

   // Year decomposition: a century counter (mod 100) and the century index mod 4.
   localparam logic [6:0]  LAST_IN_CENTURY = 7'd99;
   // Century index of the reset year 1900, taken mod 4.
   localparam logic [1:0]  FIRST_CENTURY_MOD4 = 2'd3;
   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [15:0] day_count;
   } req_type;

   typedef struct packed {
      logic [13:0] cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
      logic        error;
   } rsp_type;

   // Number of days in a month; months outside 1 to 12 read as 31.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         FEBRUARY:  len = leap ? 5'd29 : 5'd28;
         APRIL:     len = 5'd30;
         JUNE:      len = 5'd30;
         SEPTEMBER: len = 5'd30;
         NOVEMBER:  len = 5'd30;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

   // Leap rule from the low year bits, the year mod 100 and the century mod 4.
   function automatic logic leap_rule(input logic [1:0] year_low, input logic [6:0] mod100,
                                      input logic [1:0] century_mod4);
      return ((year_low == 2'd0) && (mod100 != 7'd0)) ||
             ((mod100 == 7'd0) && (century_mod4 == 2'd0));
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gregorian_date_day_stepper_core.sv =====
`default_nettype none

// Holds one Gregorian date (1 Jan 1900 to 31 Dec 9999) and answers every request
// transfer with exactly one response transfer carrying the held date and an error
// flag. A load passes through the year-by-100 split, then the range check, and
// then the fill of the output register. An add or subtract moves the date one
// day per clock through a single day-step unit, min(day_count, MAX_DAY_COUNT)
// days in all, and stops early with the error flag set when a calendar bound is
// reached. The request side is ready again in the cycle the response appears.
// The block takes no new request until the current one has finished, and a
// finished response waits in its output register until it is taken; while it
// waits, the next item holds in its finish step.
module gregorian_date_day_stepper_core #(
   parameter int MAX_DAY_COUNT = 65535
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  gdds_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output gdds_pkg::rsp_type   rsp_data
);

   localparam int CNT_W = $clog2(MAX_DAY_COUNT + 1);
   localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LDQ    = 3'd1;
   localparam logic [2:0] ST_LDCHK  = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   gdds_pkg::req_type req_ff, req_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        quot_ff, quot_in;
   logic              err_ff, err_in;
   logic [13:0]       year_ff, year_in;
   logic [3:0]        month_ff, month_in;
   logic [4:0]        day_ff, day_in;
   logic [6:0]        mod100_ff, mod100_in;
   logic [1:0]        cent4_ff, cent4_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gdds_pkg::rsp_type rsp_ff, rsp_in;

   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  count_max;
   logic [CMP_W-1:0]  count_clamp;
   logic [26:0]       ld_prod;
   logic [13:0]       ld_hund;
   logic [13:0]       ld_rem;
   logic              ld_leap;
   logic              ld_ok;
   logic              cur_leap;
   logic [4:0]        cur_len;
   logic [4:0]        prev_len;
   logic              slot_free;

   // Clamp the requested day count to the configured maximum.
   assign count_ext   = CMP_W'(req_data.day_count);
   assign count_max   = CMP_W'(MAX_DAY_COUNT);
   assign count_clamp = (count_ext > count_max) ? count_max : count_ext;

   // Quotient by 100 of the load year through a reciprocal multiply.
   assign ld_prod = 27'(req_ff.load_year) * 27'(gdds_pkg::RECIP_100);

   // Remainder by 100 as shift-and-add, then the load validity check.
   assign ld_hund = 14'({quot_ff, 6'b0}) + 14'({quot_ff, 5'b0}) + 14'({quot_ff, 2'b0});
   assign ld_rem  = req_ff.load_year - ld_hund;
   assign ld_leap = gdds_pkg::leap_rule(req_ff.load_year[1:0], ld_rem[6:0], quot_ff[1:0]);
   assign ld_ok   = (req_ff.load_year >= gdds_pkg::FIRST_YEAR) &&
                    (req_ff.load_year <= gdds_pkg::LAST_YEAR) &&
                    (req_ff.load_month >= gdds_pkg::JANUARY) &&
                    (req_ff.load_month <= gdds_pkg::DECEMBER) &&
                    (req_ff.load_day >= gdds_pkg::FIRST_DAY) &&
                    (req_ff.load_day <= gdds_pkg::month_len(req_ff.load_month, ld_leap));

   // Month lengths around the held date for the day-step unit.
   assign cur_leap = gdds_pkg::leap_rule(year_ff[1:0], mod100_ff, cent4_ff);
   assign cur_len  = gdds_pkg::month_len(month_ff, cur_leap);
   assign prev_len = gdds_pkg::month_len(month_ff - 4'd1, cur_leap);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer and the shared day-step unit.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      quot_in      = quot_ff;
      err_in       = err_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      mod100_in    = mod100_ff;
      cent4_in     = cent4_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cnt_in = count_clamp[CNT_W-1:0];
               err_in = 1'b0;
               case (req_data.command)
                  gdds_pkg::CMD_LOAD: state_in = ST_LDQ;
                  gdds_pkg::CMD_ADD:  state_in = ST_STEP;
                  gdds_pkg::CMD_SUB:  state_in = ST_STEP;
                  default:            state_in = ST_FINISH;
               endcase
            end
         end
         ST_LDQ: begin
            quot_in  = ld_prod[gdds_pkg::RECIP_SHIFT +: 8];
            state_in = ST_LDCHK;
         end
         ST_LDCHK: begin
            if (ld_ok) begin
               year_in   = req_ff.load_year;
               month_in  = req_ff.load_month;
               day_in    = req_ff.load_day;
               mod100_in = ld_rem[6:0];
               cent4_in  = quot_ff[1:0];
            end else begin
               err_in = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (req_ff.command == gdds_pkg::CMD_ADD) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (day_ff < cur_len) begin
                  day_in = day_ff + 5'd1;
               end else if (month_ff < gdds_pkg::DECEMBER) begin
                  month_in = month_ff + 4'd1;
                  day_in   = gdds_pkg::FIRST_DAY;
               end else if (year_ff >= gdds_pkg::LAST_YEAR) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  year_in  = year_ff + 14'd1;
                  month_in = gdds_pkg::JANUARY;
                  day_in   = gdds_pkg::FIRST_DAY;
                  if (mod100_ff == gdds_pkg::LAST_IN_CENTURY) begin
                     mod100_in = 7'd0;
                     cent4_in  = cent4_ff + 2'd1;
                  end else begin
                     mod100_in = mod100_ff + 7'd1;
                  end
               end
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (day_ff > gdds_pkg::FIRST_DAY) begin
                  day_in = day_ff - 5'd1;
               end else if (month_ff > gdds_pkg::JANUARY) begin
                  month_in = month_ff - 4'd1;
                  day_in   = prev_len;
               end else if (year_ff <= gdds_pkg::FIRST_YEAR) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  year_in  = year_ff - 14'd1;
                  month_in = gdds_pkg::DECEMBER;
                  day_in   = gdds_pkg::LAST_DAY_OF_DECEMBER;
                  if (mod100_ff == 7'd0) begin
                     mod100_in = gdds_pkg::LAST_IN_CENTURY;
                     cent4_in  = cent4_ff - 2'd1;
                  end else begin
                     mod100_in = mod100_ff - 7'd1;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.cur_year    = year_ff;
               rsp_in.cur_month   = month_ff;
               rsp_in.cur_day     = day_ff;
               rsp_in.error       = err_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the held date.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         year_ff      <= gdds_pkg::FIRST_YEAR;
         month_ff     <= gdds_pkg::JANUARY;
         day_ff       <= gdds_pkg::FIRST_DAY;
         mod100_ff    <= 7'd0;
         cent4_ff     <= gdds_pkg::FIRST_CENTURY_MOD4;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         mod100_ff    <= mod100_in;
         cent4_ff     <= cent4_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      quot_ff <= quot_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   // The held month never leaves the calendar range.
   assert property (@(posedge clock) disable iff (reset)
      (month_ff >= gdds_pkg::JANUARY) && (month_ff <= gdds_pkg::DECEMBER))
      else $error("held month out of range");

   // The held day fits the length of the held month.
   assert property (@(posedge clock) disable iff (reset)
      (day_ff >= gdds_pkg::FIRST_DAY) && (day_ff <= cur_len))
      else $error("held day past end of month");

   // Each stepping cycle that stays in the step state uses up one day of the count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) && (state_in == ST_STEP) |=>
      (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("day counter did not advance");

   // A response is only loaded when the output register is free or being taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire
